// ===== src/poly_additive_flute_voice_macros.svh =====
// Assertion macros used by the flute voice engine
`ifndef POLY_ADDITIVE_FLUTE_VOICE_MACROS_SVH
`define POLY_ADDITIVE_FLUTE_VOICE_MACROS_SVH

// plain property, sampled on the clock, off while in reset
`define PAFV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition now implies consequence in the next cycle
`define PAFV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pafv_pkg.sv =====
// Types, constants and pitch tables of the flute voice
package pafv_pkg;

  localparam int VOICES          = 8;
  localparam int BLOCK_LEN       = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 24;
  localparam int PADS            = 12;
  localparam int QUEUE_DEPTH     = 2;

  localparam int VOICE_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W    = $clog2(VOICES + 1);
  localparam int BLK_W    = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int QD_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int MASK_W   = 12;
  localparam int TDATA_W  = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FUND_W   = 24;
  localparam int AMP_W    = 17;
  localparam int SAMPLE_W = 16;
  localparam int RATIO_W  = 18;
  localparam int STEP_W   = 26;
  localparam int ACC_W    = 34;
  localparam int SUM_W    = 53 + VOICE_W;
  localparam int MAG_W    = SUM_W - 32;
  localparam int GAIN_W   = 31;
  localparam int PM_W     = MAG_W + GAIN_W;
  localparam int DCNT_W   = $clog2(PM_W);

  localparam logic [AMP_W-1:0] FULL_AMP    = 17'd65536;
  localparam logic [AMP_W-1:0] AUDIBLE_MIN = 17'd66;
  localparam logic [11:0] VIB_DEPTH_MAX  = 12'd3072;
  localparam logic [16:0] TREM_DEPTH_MAX = 17'd65536;
  localparam logic [15:0] COEF_H1   = 16'd45875;
  localparam logic [15:0] COEF_H2   = 16'd13107;
  localparam logic [15:0] COEF_H3   = 16'd6554;
  localparam logic [15:0] HEADROOM  = 16'd55706;
  localparam logic [14:0] SAMPLE_MAX = 15'd32767;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MASTER_VOLUME     = 3'd0,
    REG_AMP_STEP          = 3'd1,
    REG_VIBRATO_INCREMENT = 3'd2,
    REG_VIBRATO_DEPTH     = 3'd3,
    REG_TREMOLO_DEPTH     = 3'd4,
    REG_BASE_INCREMENT    = 3'd5
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ALLOC, ST_RELEASE, ST_AMP, ST_LFO, ST_VIB, ST_RATIO, ST_STEP,
    ST_TREM, ST_PHASE, ST_H1, ST_H2, ST_H3, ST_VAL, ST_MUL1, ST_MUL2,
    ST_GAIN, ST_PROD, ST_DIV, ST_OUT
  } eng_state_e;

  typedef struct packed {
    logic              valid;
    logic [MASK_W-1:0] mask;
  } mask_item_t;

  typedef struct packed {
    logic                       busy;
    logic                       done;
    logic signed [SAMPLE_W-1:0] value;
  } sine_stat_t;

  function automatic logic [16:0] semi_ratio(input logic [3:0] k);
    logic [16:0] r;
    unique case (k)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd69433;
      4'd2:  r = 17'd73562;
      4'd3:  r = 17'd77936;
      4'd4:  r = 17'd82570;
      4'd5:  r = 17'd87480;
      4'd6:  r = 17'd92682;
      4'd7:  r = 17'd98193;
      4'd8:  r = 17'd104032;
      4'd9:  r = 17'd110218;
      4'd10: r = 17'd116772;
      4'd11: r = 17'd123715;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [RATIO_W-1:0] oct_ratio(input logic [4:0] n);
    logic [4:0]  k;
    logic [1:0]  oct;
    logic [18:0] wide;
    priority if (n >= 5'd24) begin
      k = 5'd0;
      oct = 2'd2;
    end else if (n >= 5'd12) begin
      k = n - 5'd12;
      oct = 2'd1;
    end else begin
      k = n;
      oct = 2'd0;
    end
    wide = {2'b00, semi_ratio(k[3:0])} << oct;
    return wide[18:1];
  endfunction

endpackage

// ===== src/pafv_front.sv =====
// Input side: accepts touch masks into a short queue
module pafv_front import pafv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [11:0] touch_mask
  input  logic               pop_i,
  output mask_item_t         item_o
);

  logic [MASK_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QD_W-1:0]   wr_q, rd_q;
  logic [QD_W:0]     cnt_q;
  logic              push, pop;

  assign s_axis_tready = (cnt_q < (QD_W+1)'(QUEUE_DEPTH));
  assign push = s_axis_tvalid && s_axis_tready;
  assign pop  = pop_i && (cnt_q != '0);

  assign item_o.valid = (cnt_q != '0);
  assign item_o.mask  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= s_axis_tdata[MASK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QD_W'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QD_W'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QD_W+1)'(push) - (QD_W+1)'(pop);
    end
  end

endmodule

// ===== src/pafv_sine.sv =====
// Shared sine unit: rational sine approximation by serial division
module pafv_sine import pafv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output sine_stat_t            stat_o
);

  localparam int SB       = SINE_TABLE_BITS;
  localparam int SIN_H    = 1 << (SB - 1);
  localparam int P_W      = 2 * SB - 2;
  localparam int DEN_W    = 2 * SB + 1;
  localparam int NUM_W    = 2 * SB + 17;
  localparam int Q_W      = 16;
  localparam int QC_W     = $clog2(Q_W + 1);
  localparam int FIVE_HH  = 5 * SIN_H * SIN_H;

  logic [SB-1:0]      idx, hmj;
  logic [SB-2:0]      j;
  logic [2*SB-2:0]    jprod;
  logic [P_W-1:0]     p;
  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   num;
  logic [DEN_W:0]     trial;
  logic               ge;

  logic [DEN_W-1:0]   rem_q, den_q;
  logic [Q_W-1:0]     lo_q;
  logic [QC_W-1:0]    cnt_q;
  logic               busy_q, neg_q;

  assign idx   = phase_i[PHASE_BITS-1 -: SB];
  assign j     = idx[SB-2:0];
  assign hmj   = SB'(SIN_H) - {1'b0, j};
  assign jprod = j * hmj;
  assign p     = P_W'(jprod);
  assign den   = DEN_W'(FIVE_HH) - (DEN_W'(p) << 2);
  assign num   = (NUM_W'(p) << 19) - (NUM_W'(p) << 4) + NUM_W'(den >> 1);

  assign trial = {rem_q, lo_q[Q_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = busy_q && (cnt_q == QC_W'(Q_W));
  assign stat_o.value = neg_q ? -$signed(lo_q) : $signed(lo_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DEN_W'(num >> Q_W);
      lo_q  <= num[Q_W-1:0];
      den_q <= den;
      neg_q <= idx[SB-1];
    end else if (busy_q && (cnt_q != QC_W'(Q_W))) begin
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      lo_q  <= {lo_q[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == QC_W'(Q_W)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

endmodule

// ===== src/pafv_engine.sv =====
// Back end: voice allocation, per-voice synthesis, mix and output register
module pafv_engine import pafv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mask_item_t            item_i,
  output logic                  pop_o,
  output logic                  sine_start_o,
  output logic [PHASE_BITS-1:0] sine_phase_o,
  input  sine_stat_t            sine_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [15:0] sample
  output logic                  m_axis_tlast    // last_in_block
);

`include "poly_additive_flute_voice_macros.svh"

  logic [14:0] mvol_q;
  logic [15:0] amp_step_q;
  logic [23:0] vib_inc_q;
  logic [11:0] vib_depth_q;
  logic [16:0] trem_depth_q;
  logic [23:0] base_inc_q;

  eng_state_e state_q, state_d;

  logic                  busy_q [VOICES];
  logic                  busy_d [VOICES];
  logic                  on_q   [VOICES];
  logic                  on_d   [VOICES];
  logic [AMP_W-1:0]      amp_q  [VOICES];
  logic [AMP_W-1:0]      amp_d  [VOICES];
  logic [3:0]            pad_q  [VOICES];
  logic [3:0]            pad_d  [VOICES];
  logic [FUND_W-1:0]     fund_q [VOICES];
  logic [FUND_W-1:0]     fund_d [VOICES];
  logic [PHASE_BITS-1:0] ph1_q  [VOICES];
  logic [PHASE_BITS-1:0] ph1_d  [VOICES];
  logic [PHASE_BITS-1:0] ph2_q  [VOICES];
  logic [PHASE_BITS-1:0] ph2_d  [VOICES];
  logic [PHASE_BITS-1:0] ph3_q  [VOICES];
  logic [PHASE_BITS-1:0] ph3_d  [VOICES];
  logic [PHASE_BITS-1:0] vph_q  [VOICES];
  logic [PHASE_BITS-1:0] vph_d  [VOICES];

  logic [MASK_W-1:0]          mask_q, mask_d;
  logic [3:0]                 padc_q, padc_d;
  logic [VOICE_W-1:0]         voice_q, voice_d;
  logic [BLK_W-1:0]           smp_q, smp_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [15:0]         lfo_q, lfo_d;
  logic signed [12:0]         s_q, s_d;
  logic [RATIO_W-1:0]         ratio_q, ratio_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic [AMP_W-1:0]           trem_q, trem_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [15:0]         val_q, val_d;
  logic signed [33:0]         va_q, va_d;
  logic [MAG_W-1:0]           mmag_q, mmag_d;
  logic [GAIN_W-1:0]          gain_q, gain_d;
  logic [PM_W-1:0]            pm_q, pm_d;
  logic [CNT_W-1:0]           rem_q, rem_d;
  logic [DCNT_W-1:0]          dcnt_q, dcnt_d;
  logic                       neg_q, neg_d;
  logic                       ovalid_q, olast_q;
  logic [SAMPLE_W-1:0]        osample_q;

  logic                  playing, free_found, last_voice, out_load, out_last;
  logic [VOICE_W-1:0]    free_v;
  logic [40:0]           fs_prod;
  logic [24:0]           fs;
  logic [AMP_W-1:0]      target, amp_cur, amp_new;
  logic [AMP_W:0]        amp_up, amp_lim;
  logic signed [28:0]    vprod, vbias;
  logic signed [13:0]    tsum;
  logic [12:0]           tu;
  logic [RATIO_W-1:0]    r0, r1, rdiff;
  logic [25:0]           rprod;
  logic [41:0]           sprod;
  logic [16:0]           loff;
  logic [33:0]           tprod;
  logic [STEP_W+1:0]     step3;
  logic [PHASE_BITS-1:0] ph1n;
  logic [15:0]           coef;
  logic signed [32:0]    hterm;
  logic signed [ACC_W-1:0] vacc;
  logic signed [51:0]    vt;
  logic [SUM_W-1:0]      sabs;
  logic [CNT_W:0]        dtrial;
  logic                  dge;
  logic [PM_W-32:0]      qhi;
  logic [14:0]           rmag;
  logic [SAMPLE_W-1:0]   out_sample;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvol_q       <= 15'd16000;
      amp_step_q   <= 16'd66;
      vib_inc_q    <= 24'd1748;
      vib_depth_q  <= 12'd77;
      trem_depth_q <= 17'd6554;
      base_inc_q   <= 24'd91447;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MASTER_VOLUME:     mvol_q     <= cfg_wdata_i[14:0];
        REG_AMP_STEP:          amp_step_q <= cfg_wdata_i[15:0];
        REG_VIBRATO_INCREMENT: vib_inc_q  <= cfg_wdata_i;
        REG_VIBRATO_DEPTH:
          vib_depth_q <= (cfg_wdata_i[11:0] > VIB_DEPTH_MAX) ? VIB_DEPTH_MAX
                                                             : cfg_wdata_i[11:0];
        REG_TREMOLO_DEPTH:
          trem_depth_q <= (cfg_wdata_i[16:0] > TREM_DEPTH_MAX) ? TREM_DEPTH_MAX
                                                               : cfg_wdata_i[16:0];
        REG_BASE_INCREMENT:    base_inc_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // lookups over all voices
  always_comb begin
    playing    = 1'b0;
    free_found = 1'b0;
    free_v     = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (busy_q[v] && (pad_q[v] == padc_q)) begin
        playing = 1'b1;
      end
      if (!busy_q[v]) begin
        free_found = 1'b1;
        free_v     = VOICE_W'(v);
      end
    end
  end

  assign fs_prod = base_inc_q * semi_ratio(padc_q) + 41'd32768;
  assign fs      = fs_prod[40:16];

  assign amp_cur = amp_q[voice_q];
  assign target  = on_q[voice_q] ? FULL_AMP : '0;
  assign amp_up  = {1'b0, amp_cur} + {2'b00, amp_step_q};
  assign amp_lim = {1'b0, target} + {2'b00, amp_step_q};
  always_comb begin
    priority if (amp_cur < target) begin
      amp_new = (amp_up > {1'b0, target}) ? target : amp_up[AMP_W-1:0];
    end else if (amp_cur > target) begin
      amp_new = ({1'b0, amp_cur} > amp_lim) ? amp_cur - {1'b0, amp_step_q} : target;
    end else begin
      amp_new = amp_cur;
    end
  end

  assign vprod = lfo_q * $signed({1'b0, vib_depth_q});
  assign vbias = vprod + (vprod[28] ? 29'sd32767 : 29'sd0);

  assign tsum = {s_q[12], s_q} + 14'sd3072;
  always_comb begin
    priority if (tsum < 14'sd0) begin
      tu = '0;
    end else if (tsum > 14'sd6144) begin
      tu = 13'd6144;
    end else begin
      tu = tsum[12:0];
    end
  end
  assign r0    = oct_ratio(tu[12:8]);
  assign r1    = (tu[12:8] < 5'd24) ? oct_ratio(tu[12:8] + 5'd1) : r0;
  assign rdiff = r1 - r0;
  assign rprod = rdiff * tu[7:0];

  assign sprod = fund_q[voice_q] * ratio_q + 42'd32768;

  assign loff  = 17'd32768 + {lfo_q[15], lfo_q};
  assign tprod = trem_depth_q * loff;

  assign step3 = {1'b0, step_q, 1'b0} + {2'b00, step_q};
  assign ph1n  = ph1_q[voice_q] + PHASE_BITS'(step_q);

  always_comb begin
    unique case (state_q)
      ST_H1:   coef = COEF_H1;
      ST_H2:   coef = COEF_H2;
      default: coef = COEF_H3;
    endcase
  end
  assign hterm = $signed({1'b0, coef}) * sine_i.value;
  assign vacc  = acc_q + (acc_q[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));

  assign vt   = va_q * $signed({1'b0, trem_q});
  assign sabs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  assign dtrial = {rem_q, pm_q[PM_W-1]};
  assign dge    = (dtrial >= {1'b0, cnt_q});

  assign qhi        = pm_q[PM_W-1:31];
  assign rmag       = (qhi > (PM_W-31)'(SAMPLE_MAX)) ? SAMPLE_MAX : qhi[14:0];
  assign out_sample = neg_q ? -{1'b0, rmag} : {1'b0, rmag};

  assign last_voice = (voice_q == VOICE_W'(VOICES - 1));
  assign out_last   = (smp_q == BLK_W'(BLOCK_LEN - 1));

  always_comb begin
    state_d  = state_q;
    busy_d   = busy_q;
    on_d     = on_q;
    amp_d    = amp_q;
    pad_d    = pad_q;
    fund_d   = fund_q;
    ph1_d    = ph1_q;
    ph2_d    = ph2_q;
    ph3_d    = ph3_q;
    vph_d    = vph_q;
    mask_d   = mask_q;
    padc_d   = padc_q;
    voice_d  = voice_q;
    smp_d    = smp_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    lfo_d    = lfo_q;
    s_d      = s_q;
    ratio_d  = ratio_q;
    step_d   = step_q;
    trem_d   = trem_q;
    acc_d    = acc_q;
    val_d    = val_q;
    va_d     = va_q;
    mmag_d   = mmag_q;
    gain_d   = gain_q;
    pm_d     = pm_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    neg_d    = neg_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    sine_start_o = 1'b0;
    sine_phase_o = vph_q[voice_q];

    unique case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          pop_o   = 1'b1;
          mask_d  = item_i.mask;
          padc_d  = '0;
          state_d = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (mask_q[padc_q] && !playing && free_found) begin
          busy_d[free_v] = 1'b1;
          on_d[free_v]   = 1'b1;
          pad_d[free_v]  = padc_q;
          fund_d[free_v] = fs[24] ? {FUND_W{1'b1}} : fs[FUND_W-1:0];
          amp_d[free_v]  = '0;
          ph1_d[free_v]  = '0;
          ph2_d[free_v]  = '0;
          ph3_d[free_v]  = '0;
          vph_d[free_v]  = '0;
        end
        if (padc_q == 4'(PADS - 1)) begin
          state_d = ST_RELEASE;
        end else begin
          padc_d = padc_q + 4'd1;
        end
      end
      ST_RELEASE: begin
        for (int v = 0; v < VOICES; v++) begin
          if (busy_q[v] && !mask_q[pad_q[v]]) begin
            on_d[v] = 1'b0;
          end
        end
        voice_d = '0;
        smp_d   = '0;
        cnt_d   = '0;
        sum_d   = '0;
        state_d = ST_AMP;
      end
      ST_AMP: begin
        amp_d[voice_q] = amp_new;
        if (busy_q[voice_q] && !on_q[voice_q] && (amp_new < AUDIBLE_MIN)) begin
          busy_d[voice_q] = 1'b0;
        end
        if (amp_new < AUDIBLE_MIN) begin
          if (last_voice) begin
            state_d = ST_GAIN;
          end else begin
            voice_d = voice_q + 1'b1;
          end
        end else begin
          cnt_d        = cnt_q + 1'b1;
          sine_start_o = 1'b1;
          state_d      = ST_LFO;
        end
      end
      ST_LFO: begin
        if (sine_i.done) begin
          lfo_d          = sine_i.value;
          vph_d[voice_q] = vph_q[voice_q] + PHASE_BITS'(vib_inc_q);
          state_d        = ST_VIB;
        end
      end
      ST_VIB: begin
        s_d     = vbias[27:15];
        state_d = ST_RATIO;
      end
      ST_RATIO: begin
        ratio_d = r0 + rprod[25:8];
        state_d = ST_STEP;
      end
      ST_STEP: begin
        step_d  = sprod[41:16];
        state_d = ST_TREM;
      end
      ST_TREM: begin
        trem_d  = AMP_W'(18'd65536 - tprod[33:16]);
        state_d = ST_PHASE;
      end
      ST_PHASE: begin
        ph1_d[voice_q] = ph1n;
        ph2_d[voice_q] = ph2_q[voice_q] + PHASE_BITS'({step_q, 1'b0});
        ph3_d[voice_q] = ph3_q[voice_q] + PHASE_BITS'(step3);
        sine_start_o   = 1'b1;
        sine_phase_o   = ph1n;
        acc_d          = '0;
        state_d        = ST_H1;
      end
      ST_H1: begin
        if (sine_i.done) begin
          acc_d        = acc_q + ACC_W'(hterm);
          sine_start_o = 1'b1;
          sine_phase_o = ph2_q[voice_q];
          state_d      = ST_H2;
        end
      end
      ST_H2: begin
        if (sine_i.done) begin
          acc_d        = acc_q + ACC_W'(hterm);
          sine_start_o = 1'b1;
          sine_phase_o = ph3_q[voice_q];
          state_d      = ST_H3;
        end
      end
      ST_H3: begin
        if (sine_i.done) begin
          acc_d   = acc_q + ACC_W'(hterm);
          state_d = ST_VAL;
        end
      end
      ST_VAL: begin
        val_d   = vacc[31:16];
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        va_d    = val_q * $signed({1'b0, amp_q[voice_q]});
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        sum_d = sum_q + SUM_W'(vt);
        if (last_voice) begin
          state_d = ST_GAIN;
        end else begin
          voice_d = voice_q + 1'b1;
          state_d = ST_AMP;
        end
      end
      ST_GAIN: begin
        neg_d   = sum_q[SUM_W-1];
        mmag_d  = sabs[SUM_W-1:32];
        gain_d  = mvol_q * HEADROOM;
        state_d = ST_PROD;
      end
      ST_PROD: begin
        rem_d  = '0;
        dcnt_d = '0;
        if (cnt_q == '0) begin
          pm_d    = '0;
          state_d = ST_OUT;
        end else begin
          pm_d    = mmag_q * gain_q;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = dge ? CNT_W'(dtrial - {1'b0, cnt_q}) : dtrial[CNT_W-1:0];
        pm_d   = {pm_q[PM_W-2:0], dge};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(PM_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          out_load = 1'b1;
          if (out_last) begin
            state_d = ST_IDLE;
          end else begin
            smp_d   = smp_q + 1'b1;
            voice_d = '0;
            cnt_d   = '0;
            sum_d   = '0;
            state_d = ST_AMP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int v = 0; v < VOICES; v++) begin
        busy_q[v] <= 1'b0;
        on_q[v]   <= 1'b0;
        amp_q[v]  <= '0;
        ph1_q[v]  <= '0;
        ph2_q[v]  <= '0;
        ph3_q[v]  <= '0;
        vph_q[v]  <= '0;
      end
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      on_q    <= on_d;
      amp_q   <= amp_d;
      ph1_q   <= ph1_d;
      ph2_q   <= ph2_d;
      ph3_q   <= ph3_d;
      vph_q   <= vph_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q   <= pad_d;
    fund_q  <= fund_d;
    mask_q  <= mask_d;
    padc_q  <= padc_d;
    voice_q <= voice_d;
    smp_q   <= smp_d;
    sum_q   <= sum_d;
    lfo_q   <= lfo_d;
    s_q     <= s_d;
    ratio_q <= ratio_d;
    step_q  <= step_d;
    trem_q  <= trem_d;
    acc_q   <= acc_d;
    val_q   <= val_d;
    va_q    <= va_d;
    mmag_q  <= mmag_d;
    gain_q  <= gain_d;
    pm_q    <= pm_d;
    rem_q   <= rem_d;
    dcnt_q  <= dcnt_d;
    neg_q   <= neg_d;
    if (out_load) begin
      osample_q <= out_sample;
      olast_q   <= out_last;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = osample_q;
  assign m_axis_tlast  = olast_q;

  `PAFV_ASSERT(a_cnt_range, (state_q == ST_IDLE) || (cnt_q <= CNT_W'(VOICES)), "audible count above voice count")
  `PAFV_ASSERT(a_amp_full, (state_q != ST_AMP) || (amp_new <= FULL_AMP), "amplitude above full scale")
  `PAFV_ASSERT(a_sine_free, sine_start_o |-> (!sine_i.busy || sine_i.done), "sine unit restarted mid division")
  `PAFV_ASSERT_NEXT(a_take_mask, (state_q == ST_IDLE) && item_i.valid, state_q == ST_ALLOC, "queued mask not taken")

endmodule

// ===== src/poly_additive_flute_voice.sv =====
// Top level of the polyphonic additive flute voice
//
//   channel   dir  transfer when            payload
//   s_axis    in   tvalid & tready          tdata[11:0] touch_mask
//   m_axis    out  tvalid & tready          tdata[15:0] sample, tlast last_in_block
//   cfg       in   cfg_we_i high            cfg_addr_i register, cfg_wdata_i value
//
// One mask yields BLOCK_LEN samples. Taking the mask and allocating happen once per block.
// An audible voice waits four times per sample on the single shared sine divider; a
// silent voice skips those waits. The mix then scales the sum and divides it serially
// by the count of audible voices, skipping the divide when none is audible.
// Reset clears all voices at once; no clearing pass. A two-deep input queue
// and an output register let either side stall without losing a transfer.
module poly_additive_flute_voice import pafv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [11:0] touch_mask
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [15:0] sample
  output logic                  m_axis_tlast,   // last_in_block
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  mask_item_t            item;
  logic                  pop;
  logic                  sine_start;
  logic [PHASE_BITS-1:0] sine_phase;
  sine_stat_t            sine_stat;

  pafv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .pop_i         (pop),
    .item_o        (item)
  );

  pafv_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sine_start),
    .phase_i (sine_phase),
    .stat_o  (sine_stat)
  );

  pafv_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .pop_o         (pop),
    .sine_start_o  (sine_start),
    .sine_phase_o  (sine_phase),
    .sine_i        (sine_stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
